FILE: sv/glyph_outline_decoder_unit_assert.svh
// Assertion macros used by the glyph outline decoder engine.
`ifndef GLYPH_OUTLINE_DECODER_UNIT_ASSERT_SVH
`define GLYPH_OUTLINE_DECODER_UNIT_ASSERT_SVH

// Condition must never be true outside reset.
`define GOD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GOD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/god_pkg.sv
// Types and constants of the glyph outline decoder.
package god_pkg;

  typedef enum logic [3:0] {
    P_WAIT, P_COUNT, P_BBOX, P_ENDS, P_INSLEN, P_INSTR, P_FLAGS, P_REPEAT,
    P_XFETCH, P_XS, P_YFETCH, P_YS, P_DONE
  } phase_e;

  localparam logic [1:0] ST_POINT    = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_COMPOUND = 2'd2;
  localparam logic [1:0] ST_TOO_BIG  = 2'd3;

  localparam int unsigned FL_ON_CURVE = 0;
  localparam int unsigned FL_X_SHORT  = 1;
  localparam int unsigned FL_Y_SHORT  = 2;
  localparam int unsigned FL_REPEAT   = 3;
  localparam int unsigned FL_X_SAME   = 4;
  localparam int unsigned FL_Y_SAME   = 5;

  localparam logic [15:0] BBOX_BYTES = 16'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_glyph;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  point_index;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        on_curve;
    logic        contour_end;
    logic        last;
  } result_t;

endpackage

FILE: sv/god_front.sv
// Input side: accepts record bytes and queues them tagged for the parser.
module god_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_glyph_i,
  output logic              valid_o,
  output god_pkg::in_item_t item_o,
  input  logic              pop_i
);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  god_pkg::in_item_t ent_q [DEPTH];
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;
  logic [CW-1:0]     wa;
  god_pkg::in_item_t new_item;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = ent_q[0];
  assign wa      = do_pop ? cnt_q - CW'(1) : cnt_q;

  always_comb begin
    new_item.data_byte      = data_byte_i;
    new_item.start_of_glyph = start_of_glyph_i;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // each entry takes either the new byte or its upper neighbor
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (do_push && (wa == CW'(i))) begin
        ent_q[i] <= new_item;
      end else if (do_pop) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
    if (do_push && (wa == CW'(DEPTH - 1))) begin
      ent_q[DEPTH-1] <= new_item;
    end
  end
endmodule

FILE: sv/god_resq.sv
// Result queue between the parser and the output ports.
module god_resq #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  god_pkg::result_t res_i,
  output logic             full_o,
  output logic             empty_o,
  output god_pkg::result_t head_o,
  input  logic             pop_i
);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  god_pkg::result_t ent_q [DEPTH];
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;
  logic [CW-1:0]    wa;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = ent_q[0];
  assign wa      = do_pop ? cnt_q - CW'(1) : cnt_q;

  always_comb begin
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // each entry takes either the new result or its upper neighbor
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (do_push && (wa == CW'(i))) begin
        ent_q[i] <= res_i;
      end else if (do_pop) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
    if (do_push && (wa == CW'(DEPTH - 1))) begin
      ent_q[DEPTH-1] <= res_i;
    end
  end
endmodule

FILE: sv/god_engine.sv
// Parser engine: header, contour ends, flags, coordinates and point output.
`include "glyph_outline_decoder_unit_assert.svh"
module god_engine #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned MAX_CONTOURS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  god_pkg::in_item_t in_item_i,
  output logic              in_pop_o,
  input  logic              out_full_i,
  output logic              res_push_o,
  output god_pkg::result_t  res_o
);
  localparam int unsigned PW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned PIW = $clog2(MAX_POINTS);
  localparam int unsigned CPW = $clog2(MAX_CONTOURS + 1);
  localparam int unsigned CIW = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;

  god_pkg::phase_e   ph_q, ph_d;
  logic              bp_q, bp_d, rp_q, rp_d;
  logic [7:0]        held_q, held_d, lastf_q, lastf_d;
  logic [CPW-1:0]    cnt_q, cnt_d, cp_q, cp_d;
  logic [15:0]       skip_q, skip_d;
  logic [PW-1:0]     pc_q, pc_d, total_q, total_d, rep_q, rep_d;
  logic signed [15:0] run_q, run_d;

  logic [7:0]  flag_mem [MAX_POINTS];
  logic [15:0] x_mem    [MAX_POINTS];
  logic [15:0] end_mem  [MAX_CONTOURS];
  logic [7:0]  rd_flag_q;
  logic [15:0] rd_x_q, rd_end_q;

  logic        flag_we, x_we, end_we;
  logic [7:0]  flag_wd;
  logic [15:0] x_wd, end_wd;
  logic [PIW-1:0] pc_idx;
  logic [CIW-1:0] cp_idx;

  logic        go, is_y, sh, sm, need0, need1, byte_state, ce_hit, last_pt;
  logic [7:0]  b;
  logic [15:0] word;
  logic signed [17:0] delta, sum;
  logic signed [15:0] run_new;
  logic [PW-1:0] room;

  assign pc_idx = pc_q[PIW-1:0];
  assign cp_idx = cp_q[CIW-1:0];
  assign b      = in_item_i.data_byte;
  assign word   = {held_q, b};
  assign go     = !out_full_i;
  assign is_y   = (ph_q == god_pkg::P_YS);
  assign sh     = is_y ? rd_flag_q[god_pkg::FL_Y_SHORT] : rd_flag_q[god_pkg::FL_X_SHORT];
  assign sm     = is_y ? rd_flag_q[god_pkg::FL_Y_SAME] : rd_flag_q[god_pkg::FL_X_SAME];
  assign need1  = sh;
  assign need0  = !sh && sm;
  assign room   = total_q - pc_q;
  assign ce_hit = (cp_q < cnt_q) && (rd_end_q == 16'(pc_idx));
  assign last_pt = (pc_q + PW'(1) == total_q);

  always_comb begin
    if (need1) begin
      delta = sm ? 18'(b) : -18'(b);
    end else begin
      delta = 18'(signed'(word));
    end
    sum = 18'(run_q) + delta;
    if (sum > 18'sd32767) begin
      run_new = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      run_new = -16'sh8000;
    end else begin
      run_new = sum[15:0];
    end
  end

  always_comb begin
    case (ph_q)
      god_pkg::P_XS, god_pkg::P_YS: byte_state = (pc_q < total_q) && !need0;
      god_pkg::P_REPEAT, god_pkg::P_XFETCH, god_pkg::P_YFETCH: byte_state = 1'b0;
      default: byte_state = 1'b1;
    endcase
  end

  always_comb begin
    ph_d = ph_q; bp_d = bp_q; rp_d = rp_q; held_d = held_q; lastf_d = lastf_q;
    cnt_d = cnt_q; cp_d = cp_q; skip_d = skip_q; pc_d = pc_q; total_d = total_q;
    rep_d = rep_q; run_d = run_q;
    flag_we = 1'b0; flag_wd = b; x_we = 1'b0; x_wd = run_q;
    end_we = 1'b0; end_wd = word;
    in_pop_o = 1'b0; res_push_o = 1'b0; res_o = '0;
    if (go && byte_state && in_valid_i) begin
      in_pop_o = 1'b1;
      if (in_item_i.start_of_glyph) begin
        held_d = b;
        bp_d   = 1'b0;
        ph_d   = god_pkg::P_COUNT;
      end else begin
        case (ph_q)
          god_pkg::P_COUNT: begin
            if (word[15] || word == '0 || word > 16'(MAX_CONTOURS)) begin
              res_push_o  = 1'b1;
              res_o.last  = 1'b1;
              res_o.status = word[15] ? god_pkg::ST_COMPOUND :
                             (word == '0) ? god_pkg::ST_EMPTY : god_pkg::ST_TOO_BIG;
              ph_d = god_pkg::P_DONE;
            end else begin
              cnt_d  = CPW'(word);
              skip_d = god_pkg::BBOX_BYTES;
              ph_d   = god_pkg::P_BBOX;
            end
          end
          god_pkg::P_BBOX: begin
            skip_d = skip_q - 16'd1;
            if (skip_q == 16'd1) begin
              ph_d = god_pkg::P_ENDS; cp_d = '0; bp_d = 1'b0;
            end
          end
          god_pkg::P_ENDS: begin
            if (!bp_q) begin
              held_d = b; bp_d = 1'b1;
            end else begin
              bp_d   = 1'b0;
              end_we = 1'b1;
              if (cp_q + CPW'(1) >= cnt_q) begin
                cp_d = '0;
                if (word >= 16'(MAX_POINTS)) begin
                  res_push_o   = 1'b1;
                  res_o.last   = 1'b1;
                  res_o.status = god_pkg::ST_TOO_BIG;
                  ph_d = god_pkg::P_DONE;
                end else begin
                  total_d = PW'(word + 16'd1);
                  ph_d    = god_pkg::P_INSLEN;
                end
              end else begin
                cp_d = cp_q + CPW'(1);
              end
            end
          end
          god_pkg::P_INSLEN: begin
            if (!bp_q) begin
              held_d = b; bp_d = 1'b1;
            end else begin
              bp_d = 1'b0; skip_d = word; pc_d = '0; rp_d = 1'b0;
              ph_d = (word != '0) ? god_pkg::P_INSTR : god_pkg::P_FLAGS;
            end
          end
          god_pkg::P_INSTR: begin
            skip_d = skip_q - 16'd1;
            if (skip_q == 16'd1) ph_d = god_pkg::P_FLAGS;
          end
          god_pkg::P_FLAGS: begin
            if (rp_q) begin
              rp_d  = 1'b0;
              rep_d = (9'(b) < 9'(room)) ? PW'(b) : room;
              ph_d  = god_pkg::P_REPEAT;
            end else begin
              flag_we = 1'b1; lastf_d = b; pc_d = pc_q + PW'(1);
              if (b[god_pkg::FL_REPEAT]) begin
                rp_d = 1'b1;
              end else if (pc_q + PW'(1) >= total_q) begin
                ph_d = god_pkg::P_XFETCH; pc_d = '0; run_d = '0; bp_d = 1'b0;
              end
            end
          end
          god_pkg::P_XS, god_pkg::P_YS: begin
            if (!need1 && !bp_q) begin
              held_d = b; bp_d = 1'b1;
            end else begin
              bp_d  = 1'b0;
              run_d = run_new;
              pc_d  = pc_q + PW'(1);
              if (is_y) begin
                res_push_o        = 1'b1;
                res_o.status      = god_pkg::ST_POINT;
                res_o.point_index = 6'(pc_q);
                res_o.x_coord     = rd_x_q;
                res_o.y_coord     = run_new;
                res_o.on_curve    = rd_flag_q[god_pkg::FL_ON_CURVE];
                res_o.contour_end = ce_hit;
                res_o.last        = last_pt;
                if (ce_hit) cp_d = cp_q + CPW'(1);
                ph_d = god_pkg::P_YFETCH;
              end else begin
                x_we = 1'b1; x_wd = run_new;
                ph_d = god_pkg::P_XFETCH;
              end
            end
          end
          default: ;
        endcase
      end
    end else if (go && !byte_state) begin
      case (ph_q)
        god_pkg::P_REPEAT: begin
          if (rep_q == '0) begin
            if (pc_q >= total_q) begin
              ph_d = god_pkg::P_XFETCH; pc_d = '0; run_d = '0; bp_d = 1'b0;
            end else begin
              ph_d = god_pkg::P_FLAGS;
            end
          end else begin
            flag_we = 1'b1; flag_wd = lastf_q;
            pc_d = pc_q + PW'(1); rep_d = rep_q - PW'(1);
          end
        end
        god_pkg::P_XFETCH: ph_d = god_pkg::P_XS;
        god_pkg::P_YFETCH: ph_d = god_pkg::P_YS;
        god_pkg::P_XS: begin
          if (pc_q >= total_q) begin
            ph_d = god_pkg::P_YFETCH; pc_d = '0; run_d = '0; bp_d = 1'b0; cp_d = '0;
          end else begin
            x_we = 1'b1; pc_d = pc_q + PW'(1); ph_d = god_pkg::P_XFETCH;
          end
        end
        god_pkg::P_YS: begin
          if (pc_q >= total_q) begin
            ph_d = god_pkg::P_DONE;
          end else begin
            res_push_o        = 1'b1;
            res_o.status      = god_pkg::ST_POINT;
            res_o.point_index = 6'(pc_q);
            res_o.x_coord     = rd_x_q;
            res_o.y_coord     = run_q;
            res_o.on_curve    = rd_flag_q[god_pkg::FL_ON_CURVE];
            res_o.contour_end = ce_hit;
            res_o.last        = last_pt;
            if (ce_hit) cp_d = cp_q + CPW'(1);
            pc_d = pc_q + PW'(1);
            ph_d = god_pkg::P_YFETCH;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= god_pkg::P_WAIT; bp_q <= 1'b0; rp_q <= 1'b0; held_q <= '0;
      lastf_q <= '0; cnt_q <= '0; cp_q <= '0; skip_q <= '0; pc_q <= '0;
      total_q <= '0; rep_q <= '0; run_q <= '0;
    end else begin
      ph_q <= ph_d; bp_q <= bp_d; rp_q <= rp_d; held_q <= held_d;
      lastf_q <= lastf_d; cnt_q <= cnt_d; cp_q <= cp_d; skip_q <= skip_d; pc_q <= pc_d;
      total_q <= total_d; rep_q <= rep_d; run_q <= run_d;
    end
  end

  // point and contour-end stores: one write port each, registered read at the current point or contour
  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[pc_idx] <= flag_wd;
    if (x_we) x_mem[pc_idx] <= x_wd;
    if (end_we) end_mem[cp_idx] <= end_wd;
    rd_flag_q <= flag_mem[pc_idx];
    rd_x_q    <= x_mem[pc_idx];
    rd_end_q  <= end_mem[cp_idx];
  end

  `GOD_ASSERT_NEVER(a_push_full, clk_i, rst_ni, res_push_o && out_full_i, "push into full queue")
  `GOD_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, in_pop_o && !in_valid_i, "pop of empty input")
  `GOD_ASSERT_IMP(a_pc_bound, clk_i, rst_ni, ph_q == god_pkg::P_XS || ph_q == god_pkg::P_YS, pc_q <= total_q, "point counter overran")
  `GOD_ASSERT_IMP(a_cp_bound, clk_i, rst_ni, ph_q == god_pkg::P_YS, cp_q <= cnt_q, "contour pointer overran")
endmodule

FILE: sv/glyph_outline_decoder_unit.sv
// Top level of the glyph outline decoder: input queue, parser, result queue.
//
//  channel   handshake          payload
//  input     push / full        data_byte_i, start_of_glyph_i
//  result    empty / pop        status_o, point_index_o, x_coord_o, y_coord_o,
//                               on_curve_o, contour_end_o, last_o
//
// Header, box, end, length, instruction and flag bytes are each taken straight
// from the input queue; a repeat count copies the last flag once per repeat.
// In the x and y passes each point first fetches its flag from the store, then
// takes one delta byte if short, two if long, none if the same bit is set.
// Reset clears all control state; the point stores hold no reset value.
// A full result queue halts the parser, so the input queue fills and full rises.
module glyph_outline_decoder_unit #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned MAX_CONTOURS = 16,
  parameter int unsigned IN_DEPTH     = 2,
  parameter int unsigned RES_DEPTH    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               start_of_glyph_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status_o,
  output logic [5:0]         point_index_o,
  output logic signed [15:0] x_coord_o,
  output logic signed [15:0] y_coord_o,
  output logic               on_curve_o,
  output logic               contour_end_o,
  output logic               last_o
);
  god_pkg::in_item_t item;
  god_pkg::result_t  res, head;
  logic in_valid, in_pop, res_push, res_full;

  // front: byte queue
  god_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .data_byte_i,
    .start_of_glyph_i, .valid_o(in_valid), .item_o(item), .pop_i(in_pop)
  );

  // back: record parser
  god_engine #(.MAX_POINTS(MAX_POINTS), .MAX_CONTOURS(MAX_CONTOURS)) u_engine (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_item_i(item), .in_pop_o(in_pop),
    .out_full_i(res_full), .res_push_o(res_push), .res_o(res)
  );

  // results wait here until popped
  god_resq #(.DEPTH(RES_DEPTH)) u_resq (
    .clk_i, .rst_ni, .push_i(res_push), .res_i(res), .full_o(res_full),
    .empty_o(empty), .head_o(head), .pop_i(pop)
  );

  assign status_o      = head.status;
  assign point_index_o = head.point_index;
  assign x_coord_o     = signed'(head.x_coord);
  assign y_coord_o     = signed'(head.y_coord);
  assign on_curve_o    = head.on_curve;
  assign contour_end_o = head.contour_end;
  assign last_o        = head.last;
endmodule
